FILE: design/length_prefixed_frame_splitter_top_assert.svh
// Assertion macros shared by the frame splitter modules.
// Depends on nothing; the caller passes clock, reset and expressions.
`ifndef LENGTH_PREFIXED_FRAME_SPLITTER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_SPLITTER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define LPFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the following cycle.
`define LPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lpfs_pkg.sv
// Shared widths, header constants and the result type of the frame splitter.
// No dependencies.
package lpfs_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_BITS   = 16;
    localparam int OFF_W      = 16;
    localparam int ID_W       = 32;
    localparam int SHIFT_W    = 24;

    localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = '1;
    localparam logic [ID_W-1:0]     HDR_LEN       = 32'd8;
    localparam logic [OFF_W-1:0]    LEN_OFF_LAST  = 16'd3;
    localparam logic [OFF_W-1:0]    ID_OFF_LAST   = 16'd7;

    typedef struct packed {
        logic [BYTE_W-1:0]   byte_out;
        logic [OFF_W-1:0]    byte_offset;
        logic [LEN_BITS-1:0] frame_length;
        logic                length_valid;
        logic [ID_W-1:0]     message_id;
        logic                id_valid;
        logic                frame_last;
        logic                length_error;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_in_req;

endpackage

FILE: design/lpfs_in_stage.sv
// Input register of the frame splitter: holds one accepted byte request.
// Depends on lpfs_pkg.
module lpfs_in_stage (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [lpfs_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                     i_advance,
    output logic                     o_stall,
    output lpfs_pkg::t_in_req        o_req
);

    logic                        r_valid;
    logic [lpfs_pkg::BYTE_W-1:0] r_data;
    logic                        load;

    // The stage takes a new request when it is empty or its request moves on.
    assign load    = !r_valid || i_advance;
    assign o_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
        if (load && i_valid) begin
            r_data <= i_data_byte;
        end
    end

    assign o_req.valid = r_valid;
    assign o_req.data  = r_data;

endmodule

FILE: design/lpfs_parse.sv
// Frame parser: header state, length check and per-byte result logic.
// Depends on lpfs_pkg and the assertion macro header.
`include "length_prefixed_frame_splitter_top_assert.svh"

module lpfs_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_max_frame_len_we,
    input  logic [lpfs_pkg::LEN_BITS-1:0] i_max_frame_len,
    input  lpfs_pkg::t_in_req             i_req,
    input  logic                          i_advance,
    output lpfs_pkg::t_result             o_result
);

    logic [lpfs_pkg::SHIFT_W-1:0]  r_hdr_shift, n_hdr_shift;
    logic [lpfs_pkg::OFF_W-1:0]    r_byte_count, n_byte_count;
    logic [lpfs_pkg::LEN_BITS-1:0] r_cap_len, n_cap_len;
    logic [lpfs_pkg::ID_W-1:0]     r_cap_id, n_cap_id;
    logic                          r_in_body, n_in_body;
    logic [lpfs_pkg::LEN_BITS-1:0] r_max_len;

    logic                          fire;
    logic [lpfs_pkg::ID_W-1:0]     word;
    logic [lpfs_pkg::OFF_W:0]      next_off;
    logic                          len_bad;

    assign fire     = i_req.valid && i_advance;
    assign word     = {r_hdr_shift, i_req.data};
    assign next_off = {1'b0, r_byte_count} + 17'd1;
    // The upper half of the length word must be zero for any legal length.
    assign len_bad  = (word < lpfs_pkg::HDR_LEN) || (word[31:16] != 16'd0)
                      || (word[15:0] > r_max_len);

    always_comb begin
        n_hdr_shift  = word[lpfs_pkg::SHIFT_W-1:0];
        n_byte_count = r_byte_count;
        n_cap_len    = r_cap_len;
        n_cap_id     = r_cap_id;
        n_in_body    = r_in_body;

        o_result              = '0;
        o_result.byte_out     = i_req.data;
        o_result.byte_offset  = r_byte_count;

        if (!r_in_body) begin
            if (r_byte_count >= lpfs_pkg::LEN_OFF_LAST) begin
                if (len_bad) begin
                    o_result.length_error = 1'b1;
                    n_hdr_shift  = '0;
                    n_byte_count = '0;
                    n_cap_len    = '0;
                    n_cap_id     = '0;
                    n_in_body    = 1'b0;
                end else begin
                    n_cap_len    = word[lpfs_pkg::LEN_BITS-1:0];
                    n_in_body    = 1'b1;
                    n_hdr_shift  = '0;
                    n_byte_count = next_off[lpfs_pkg::OFF_W-1:0];
                    o_result.frame_length = word[lpfs_pkg::LEN_BITS-1:0];
                    o_result.length_valid = 1'b1;
                end
            end else begin
                n_byte_count = next_off[lpfs_pkg::OFF_W-1:0];
            end
        end else begin
            o_result.frame_length = r_cap_len;
            o_result.length_valid = 1'b1;
            if (r_byte_count == lpfs_pkg::ID_OFF_LAST) begin
                n_cap_id            = word;
                o_result.message_id = word;
                o_result.id_valid   = 1'b1;
            end else if (r_byte_count > lpfs_pkg::ID_OFF_LAST) begin
                o_result.message_id = r_cap_id;
                o_result.id_valid   = 1'b1;
            end
            if (next_off >= {1'b0, r_cap_len}) begin
                o_result.frame_last = 1'b1;
                n_hdr_shift  = '0;
                n_byte_count = '0;
                n_cap_len    = '0;
                n_cap_id     = '0;
                n_in_body    = 1'b0;
            end else begin
                n_byte_count = next_off[lpfs_pkg::OFF_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_shift  <= '0;
            r_byte_count <= '0;
            r_cap_len    <= '0;
            r_cap_id     <= '0;
            r_in_body    <= 1'b0;
            r_max_len    <= lpfs_pkg::MAX_LEN_RESET;
        end else begin
            if (fire) begin
                r_hdr_shift  <= n_hdr_shift;
                r_byte_count <= n_byte_count;
                r_cap_len    <= n_cap_len;
                r_cap_id     <= n_cap_id;
                r_in_body    <= n_in_body;
            end
            if (i_max_frame_len_we) begin
                r_max_len <= i_max_frame_len;
            end
        end
    end

    `LPFS_ASSERT_NEXT(a_err_restarts, i_clk, i_rst_n, fire && o_result.length_error,
        !r_in_body && (r_byte_count == 16'd0), "length error did not restart the header")
    `LPFS_ASSERT_SAME(a_body_len_legal, i_clk, i_rst_n, r_in_body,
        r_cap_len >= 16'd8, "frame body entered with a length below the header size")
    `LPFS_ASSERT_SAME(a_hdr_count, i_clk, i_rst_n, !r_in_body,
        r_byte_count <= lpfs_pkg::LEN_OFF_LAST, "header offset ran past the length word")
    `LPFS_ASSERT_SAME(a_body_count, i_clk, i_rst_n, r_in_body,
        r_byte_count < r_cap_len, "body offset reached the frame length")

endmodule

FILE: design/lpfs_out_stage.sv
// Result register of the frame splitter with its valid flag.
// Depends on lpfs_pkg.
module lpfs_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lpfs_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_advance,
    output logic              o_valid,
    output lpfs_pkg::t_result o_result
);

    logic              r_valid;
    lpfs_pkg::t_result r_result;

    // The register can load when it is empty or its request is being taken.
    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/length_prefixed_frame_splitter_top.sv
// Channel    | direction | handshake           | payload
// input      | in        | i_valid / o_stall   | i_data_byte
// result     | out       | o_valid / i_stall   | o_byte_out .. o_length_error
// config     | in        | i_max_frame_len_we  | i_max_frame_len
//
// One byte request per clock when the result side does not stall; each byte
// passes the input register, the parser logic and the result register before
// its result is presented on o_valid.
// Reset is synchronous and active low; it clears the header state and sets the
// maximum length to 65535. A stall on the result side backs up to o_stall
// once both registers hold a request.
// Top level of the frame splitter; depends on lpfs_pkg and the lpfs_ modules.
module length_prefixed_frame_splitter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_max_frame_len_we,
    input  logic [15:0] i_max_frame_len,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_out,
    output logic [15:0] o_byte_offset,
    output logic [15:0] o_frame_length,
    output logic        o_length_valid,
    output logic [31:0] o_message_id,
    output logic        o_id_valid,
    output logic        o_frame_last,
    output logic        o_length_error
);

    lpfs_pkg::t_in_req in_req;
    lpfs_pkg::t_result parse_result;
    lpfs_pkg::t_result out_result;
    logic              advance;

    lpfs_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_advance   (advance),
        .o_stall     (o_stall),
        .o_req       (in_req)
    );

    lpfs_parse u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_max_frame_len_we (i_max_frame_len_we),
        .i_max_frame_len    (i_max_frame_len),
        .i_req              (in_req),
        .i_advance          (advance),
        .o_result           (parse_result)
    );

    lpfs_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_req.valid),
        .i_result  (parse_result),
        .i_stall   (i_stall),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_result  (out_result)
    );

    assign o_byte_out     = out_result.byte_out;
    assign o_byte_offset  = out_result.byte_offset;
    assign o_frame_length = out_result.frame_length;
    assign o_length_valid = out_result.length_valid;
    assign o_message_id   = out_result.message_id;
    assign o_id_valid     = out_result.id_valid;
    assign o_frame_last   = out_result.frame_last;
    assign o_length_error = out_result.length_error;

endmodule
